/* hdl/kmse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmse_pkg
// Types, codes and the host key decode table for the key matrix scan emulator.
// ----------------------------------------------------------------------------
package kmse_pkg;

  localparam int NUM_ROWS  = 10;
  localparam int ROW_W     = $clog2(NUM_ROWS);
  localparam int SELECT_W  = NUM_ROWS;
  localparam int PORT_A_ROWS = 7;

  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [15:0] BREAK_CODE = 16'hFF13;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] key_code;
    logic [7:0]  port_a_drive;
    logic [2:0]  port_b_drive;
  } kmse_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       break_active;
  } kmse_result_t;

  typedef struct packed {
    logic             hit;
    logic [ROW_W-1:0] row;
    logic [7:0]       mask;
  } kmse_key_t;

  function automatic kmse_key_t key_entry(input int row, input logic [7:0] mask);
    kmse_key_t k;
    k.hit  = 1'b1;
    k.row  = ROW_W'(row);
    k.mask = mask;
    return k;
  endfunction

  // host key code to matrix row and bit; unknown codes give no hit
  function automatic kmse_key_t key_decode(input logic [15:0] code);
    kmse_key_t k;
    k = '0;
    case (code)
      16'h0020: k = key_entry(4, 8'h80);
      16'h002D: k = key_entry(7, 8'h01);
      16'h002E: k = key_entry(9, 8'h01);
      16'h0030: k = key_entry(6, 8'h80);
      16'h0031: k = key_entry(0, 8'h04);
      16'h0032: k = key_entry(9, 8'h04);
      16'h0033: k = key_entry(8, 8'h04);
      16'h0034: k = key_entry(0, 8'h08);
      16'h0035: k = key_entry(9, 8'h08);
      16'h0036: k = key_entry(8, 8'h08);
      16'h0037: k = key_entry(0, 8'h02);
      16'h0038: k = key_entry(9, 8'h02);
      16'h0039: k = key_entry(8, 8'h02);
      16'h0061: k = key_entry(9, 8'h40);
      16'h0062: k = key_entry(1, 8'h80);
      16'h0063: k = key_entry(7, 8'h80);
      16'h0064: k = key_entry(7, 8'h40);
      16'h0065: k = key_entry(7, 8'h20);
      16'h0066: k = key_entry(0, 8'h40);
      16'h0067: k = key_entry(1, 8'h40);
      16'h0068: k = key_entry(2, 8'h40);
      16'h0069: k = key_entry(4, 8'h20);
      16'h006A: k = key_entry(3, 8'h40);
      16'h006B: k = key_entry(4, 8'h40);
      16'h006C: k = key_entry(5, 8'h40);
      16'h006D: k = key_entry(3, 8'h80);
      16'h006E: k = key_entry(2, 8'h80);
      16'h006F: k = key_entry(2, 8'h08);
      16'h0070: k = key_entry(1, 8'h08);
      16'h0071: k = key_entry(9, 8'h20);
      16'h0072: k = key_entry(0, 8'h20);
      16'h0073: k = key_entry(8, 8'h40);
      16'h0074: k = key_entry(1, 8'h20);
      16'h0075: k = key_entry(3, 8'h20);
      16'h0076: k = key_entry(0, 8'h80);
      16'h0077: k = key_entry(8, 8'h20);
      16'h0078: k = key_entry(8, 8'h80);
      16'h0079: k = key_entry(2, 8'h20);
      16'h007A: k = key_entry(9, 8'h80);
      16'h00AC: k = key_entry(7, 8'h10);
      16'h00AD: k = key_entry(2, 8'h10);
      16'h00AE: k = key_entry(0, 8'h10);
      16'h00AF: k = key_entry(1, 8'h10);
      16'hFF0D: k = key_entry(5, 8'h80);
      16'hFF52: k = key_entry(0, 8'h10);
      16'hFF54: k = key_entry(7, 8'h10);
      16'hFF51: k = key_entry(1, 8'h10);
      16'hFF53: k = key_entry(2, 8'h10);
      16'hFFAA: k = key_entry(7, 8'h04);
      16'hFFAB: k = key_entry(8, 8'h01);
      16'hFFAD: k = key_entry(7, 8'h01);
      16'hFFAF: k = key_entry(7, 8'h08);
      16'hFFE1: k = key_entry(8, 8'h10);
      16'hFFE2: k = key_entry(8, 8'h10);
      16'hFFFF: k = key_entry(7, 8'h02);
      default:  k = '0;
    endcase
    return k;
  endfunction

endpackage

/* hdl/key_matrix_scan_emulator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_scan_emulator_unit
// Keyboard matrix of 10 rows of 8 bits driven by host key events and read
// through the port A / port B scan lines.
// ----------------------------------------------------------------------------
// Takes one word per cycle while the output is not stalled: a key press, a
// key release or a port read. Each word is held in an input register, then
// decoded and applied when the output can advance, and its result is loaded
// into the result register at that same clock edge; one result leaves per
// cycle while the output is not stalled. Key events
// return read_data zero;
// a port read returns port A ORed with every row whose drive line is set
// (port A bits 0 to 6 for rows 0 to 6, port A bit 7 or port B bit 0 for
// row 7, port B bits 1 and 2 for rows 8 and 9). break_active follows the
// Break key. Reset clears the matrix and the break flag at once.
module key_matrix_scan_emulator_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  input  kmse_pkg::kmse_item_t  item,
  output logic                  result_valid,
  input  logic                  result_stall,
  output kmse_pkg::kmse_result_t result
);
  import kmse_pkg::*;

  logic         s1_valid;
  kmse_item_t   s1;
  logic         advance;

  logic [7:0]   matrix [NUM_ROWS];
  logic [7:0]   matrix_next [NUM_ROWS];
  logic         break_flag;
  logic         break_next;
  kmse_result_t result_next;
  kmse_key_t    key;
  logic [SELECT_W-1:0] row_select;

  assign advance    = !result_valid || !result_stall;
  assign item_stall = s1_valid && !advance;

  always_comb begin
    key         = key_decode(s1.key_code);
    matrix_next = matrix;
    break_next  = break_flag;
    result_next = '0;
    row_select  = {s1.port_b_drive, {PORT_A_ROWS{1'b0}}}
                | {{(SELECT_W - 8){1'b0}}, s1.port_a_drive};
    case (s1.command)
      CMD_PRESS, CMD_RELEASE: begin
        if (s1.key_code == BREAK_CODE) begin
          break_next = (s1.command == CMD_PRESS);
        end else if (key.hit) begin
          if (s1.command == CMD_PRESS) begin
            matrix_next[key.row] = matrix[key.row] | key.mask;
          end else begin
            matrix_next[key.row] = matrix[key.row] & ~key.mask;
          end
        end
      end
      CMD_READ: begin
        result_next.read_data = s1.port_a_drive;
        for (int i = 0; i < NUM_ROWS; i++) begin
          if (row_select[i]) begin
            result_next.read_data = result_next.read_data | matrix[i];
          end
        end
      end
      default: begin
      end
    endcase
    result_next.break_active = break_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      break_flag   <= 1'b0;
      for (int i = 0; i < NUM_ROWS; i++) begin
        matrix[i] <= '0;
      end
    end else begin
      if (!item_stall) begin
        s1_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= s1_valid;
        if (s1_valid) begin
          matrix     <= matrix_next;
          break_flag <= break_next;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1 <= item;
    end
    if (advance && s1_valid) begin
      result <= result_next;
    end
  end

  // stall toward the source only when the held word cannot move on
  a_stall_needs_word: assert property (@(posedge clk) item_stall |-> s1_valid)
    else $error("item_stall raised with no word held");

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !result_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_break_press: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1.command == CMD_PRESS && s1.key_code == BREAK_CODE)
      |=> (result_valid && result.break_active && result.read_data == 8'h00))
    else $error("break press not reflected in result");

  a_key_release_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && s1.command == CMD_RELEASE && key.hit
      && s1.key_code != BREAK_CODE)
      |=> ((matrix[$past(key.row)] & $past(key.mask)) == 8'h00))
    else $error("key release left its matrix bit set");

endmodule
